@@ rtl/websocket_frame_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// WebSocket frame decoder assertion macros
// Shared concurrent assertion forms for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DECODER_DEFINES_SVH
`define WEBSOCKET_FRAME_DECODER_DEFINES_SVH

// same-cycle implication
`define WSFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WSFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/wsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame decoder package
// Types and constants for the frame header parser and payload unmasker.
// ----------------------------------------------------------------------------
package wsfd_pkg;

   localparam int LengthBits = 64;
   localparam int CmpBits    = (LengthBits > 32) ? LengthBits : 32;

   localparam logic [31:0] MaxPayloadReset = 32'd65536;

   localparam logic [3:0] OpClose  = 4'h8;
   localparam logic [6:0] LenExt16 = 7'd126;
   localparam logic [6:0] LenExt64 = 7'd127;

   localparam logic [2:0] ExtCount16 = 3'd1;
   localparam logic [2:0] ExtCount64 = 3'd7;
   localparam logic [2:0] KeyCount   = 3'd3;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_SECOND,
      PH_EXTLEN,
      PH_KEY,
      PH_PAYLOAD,
      PH_HALT
   } phase_type;

   typedef enum logic [1:0] {
      ST_DATA,
      ST_EMPTY,
      ST_CLOSE,
      ST_OVER
   } status_type;

endpackage

@@ rtl/websocket_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame decoder
// Parses a received WebSocket byte stream one byte per clock while results
// are taken: frame header, 16/64-bit extended length, masking key, then
// unmasked payload bytes with a last marker. An empty frame gives an
// empty-done result, a close opcode a close result, and a length above
// csr_write_data's limit an error result; after close or error all bytes are
// dropped until reset. Each accepted byte passes an input register and one
// state update into the result register, so a byte is taken every clock
// unless a held result stalls it; the rate is set by that single per-byte
// state update. Header bytes yield only empty, close and error results. The
// length limit (reset 65536) may only be written while the block is idle.
// ----------------------------------------------------------------------------
module websocket_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_frame_opcode,
   output logic        rsp_final_flag,
   output logic        rsp_last
);
   import wsfd_pkg::*;

   `include "websocket_frame_decoder_defines.svh"

   logic [31:0]           max_payload_ff;
   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;

   phase_type             phase_ff, phase_in;
   logic [2:0]            count_ff, count_in;
   logic [LengthBits-1:0] length_ff, length_in;
   logic [LengthBits-1:0] remaining_ff, remaining_in;
   logic                  mask_ff, mask_in;
   logic [31:0]           key_ff, key_in;
   logic [1:0]            key_index_ff, key_index_in;
   logic [3:0]            opcode_ff, opcode_in;
   logic                  fin_ff, fin_in;

   logic                  rsp_valid_ff;
   logic [7:0]            rsp_byte_ff;
   status_type            rsp_status_ff;
   logic [3:0]            rsp_opcode_ff;
   logic                  rsp_fin_ff;
   logic                  rsp_last_ff;

   logic                  advance;
   logic                  emit;
   status_type            emit_status;
   logic [7:0]            emit_byte;
   logic                  emit_last;

   logic [7:0]            b;
   logic                  is_close;
   logic                  is_ext16;
   logic                  is_ext64;
   logic [LengthBits-1:0] cand_len;
   logic [LengthBits-1:0] hdr_len;
   logic                  len_over;
   logic                  hdr_zero;
   logic                  mask_sel;
   logic [LengthBits-1:0] rem_dec;
   logic [7:0]            key_byte;
   phase_type             hdr_phase;
   phase_type             done_phase;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign b        = in_byte_ff;
   assign is_close = (b[3:0] == OpClose);
   assign is_ext16 = (b[6:0] == LenExt16);
   assign is_ext64 = (b[6:0] == LenExt64);
   assign cand_len = (phase_ff == PH_SECOND) ? LengthBits'(b[6:0])
                                             : {length_ff[LengthBits-9:0], b};
   assign hdr_len  = (phase_ff == PH_KEY) ? length_ff : cand_len;
   assign len_over = CmpBits'(cand_len) > CmpBits'(max_payload_ff);
   assign hdr_zero = (hdr_len == '0);
   assign mask_sel = (phase_ff == PH_SECOND) ? b[7] : mask_ff;
   assign rem_dec  = remaining_ff - LengthBits'(1);

   always_comb begin
      case (key_index_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign hdr_phase  = hdr_zero ? PH_FIRST : PH_PAYLOAD;
   assign done_phase = len_over ? PH_HALT : (mask_sel ? PH_KEY : hdr_phase);

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         unique case (phase_ff)
            PH_FIRST:   phase_in = is_close ? PH_HALT : PH_SECOND;
            PH_SECOND:  phase_in = (is_ext16 || is_ext64) ? PH_EXTLEN : done_phase;
            PH_EXTLEN:  phase_in = (count_ff == '0) ? done_phase : PH_EXTLEN;
            PH_KEY:     phase_in = (count_ff == '0) ? hdr_phase : PH_KEY;
            PH_PAYLOAD: phase_in = (rem_dec == '0) ? PH_FIRST : PH_PAYLOAD;
            default:    phase_in = PH_HALT;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      count_in     = count_ff;
      length_in    = length_ff;
      remaining_in = remaining_ff;
      mask_in      = mask_ff;
      key_in       = key_ff;
      key_index_in = key_index_ff;
      opcode_in    = opcode_ff;
      fin_in       = fin_ff;
      emit         = 1'b0;
      emit_status  = ST_DATA;
      emit_byte    = '0;
      emit_last    = 1'b1;
      if (advance) begin
         unique case (phase_ff) inside
            PH_FIRST: begin
               fin_in    = b[7];
               opcode_in = b[3:0];
               if (is_close) begin
                  emit        = 1'b1;
                  emit_status = ST_CLOSE;
               end
            end
            PH_SECOND, PH_EXTLEN: begin
               if (phase_ff == PH_SECOND) begin
                  mask_in = b[7];
               end
               if (phase_ff == PH_SECOND && is_ext16) begin
                  length_in = '0;
                  count_in  = ExtCount16;
               end else if (phase_ff == PH_SECOND && is_ext64) begin
                  length_in = '0;
                  count_in  = ExtCount64;
               end else if (phase_ff == PH_EXTLEN && count_ff != '0) begin
                  length_in = cand_len;
                  count_in  = count_ff - 3'd1;
               end else begin
                  length_in = cand_len;
                  if (len_over) begin
                     emit        = 1'b1;
                     emit_status = ST_OVER;
                  end else if (mask_sel) begin
                     count_in = KeyCount;
                     key_in   = '0;
                  end else if (hdr_zero) begin
                     emit        = 1'b1;
                     emit_status = ST_EMPTY;
                  end else begin
                     remaining_in = hdr_len;
                     key_index_in = '0;
                  end
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], b};
               if (count_ff != '0) begin
                  count_in = count_ff - 3'd1;
               end else if (hdr_zero) begin
                  emit        = 1'b1;
                  emit_status = ST_EMPTY;
               end else begin
                  remaining_in = hdr_len;
                  key_index_in = '0;
               end
            end
            PH_PAYLOAD: begin
               key_index_in = key_index_ff + 2'd1;
               remaining_in = rem_dec;
               emit         = 1'b1;
               emit_status  = ST_DATA;
               emit_byte    = b ^ (mask_ff ? key_byte : 8'h00);
               emit_last    = (rem_dec == '0);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MaxPayloadReset;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= PH_FIRST;
         count_ff       <= '0;
         length_ff      <= '0;
         remaining_ff   <= '0;
         mask_ff        <= 1'b0;
         key_ff         <= '0;
         key_index_ff   <= '0;
         opcode_ff      <= '0;
         fin_ff         <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            max_payload_ff <= csr_write_data;
         end
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= emit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         length_ff    <= length_in;
         remaining_ff <= remaining_in;
         mask_ff      <= mask_in;
         key_ff       <= key_in;
         key_index_ff <= key_index_in;
         opcode_ff    <= opcode_in;
         fin_ff       <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance && emit) begin
         rsp_byte_ff   <= emit_byte;
         rsp_status_ff <= emit_status;
         rsp_opcode_ff <= opcode_in;
         rsp_fin_ff    <= fin_in;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_frame_opcode = rsp_opcode_ff;
   assign rsp_final_flag   = rsp_fin_ff;
   assign rsp_last         = rsp_last_ff;

   `WSFD_ASSERT_NEXT(a_halt_sticky, clock, reset, phase_ff == PH_HALT,
      phase_ff == PH_HALT, "left halt without reset")
   `WSFD_ASSERT_NOW(a_payload_nonzero, clock, reset, phase_ff == PH_PAYLOAD,
      remaining_ff != '0, "payload phase with nothing remaining")
   `WSFD_ASSERT_NOW(a_ctrl_result_last, clock, reset, rsp_valid_ff && rsp_status_ff != ST_DATA,
      rsp_last_ff && rsp_byte_ff == 8'h00, "control result without last or with data")
   `WSFD_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready,
      !advance, "stalled result overwritten")

endmodule
